// File: design/rbpw_pkg.sv
`default_nettype none

package rbpw_pkg;

   // pool geometry
   localparam int FRAMES     = 64;
   localparam int FRAME_BITS = $clog2(FRAMES);
   localparam int USE_BITS   = $clog2(FRAMES + 1);
   localparam int COUNT_BITS = 8;

   // port field widths
   localparam int KIND_BITS   = 2;
   localparam int INDEX_BITS  = 6;
   localparam int PCT_BITS    = 7;
   localparam int STATUS_BITS = 2;
   localparam int FREE_BITS   = 7;
   localparam int CSR_IDX_BITS = 1;

   // command queue between front and back, depth a power of two
   localparam int CMD_Q_DEPTH     = 2;
   localparam int CMD_Q_PTR_BITS  = $clog2(CMD_Q_DEPTH);
   localparam int CMD_Q_FILL_BITS = $clog2(CMD_Q_DEPTH + 1);

   // percent thresholds: floor(FRAMES * pct / 100) by reciprocal multiply
   localparam int PCT_MAX      = (1 << PCT_BITS) - 1;
   localparam int PCT_DIV      = 100;
   localparam int THR_BITS     = $clog2(FRAMES * PCT_MAX / PCT_DIV + 1);
   localparam int SCALED_BITS  = PCT_BITS + FRAME_BITS + 1;
   localparam int RECIP_SHIFT  = 32;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
   localparam int RECIP_BITS   = 26;
   localparam int PROD_BITS    = SCALED_BITS + RECIP_BITS;
   localparam int LOW_PCT_RST  = 25;
   localparam int HIGH_PCT_RST = 75;
   localparam int THR_LOW_RST  = FRAMES * LOW_PCT_RST / PCT_DIV;
   localparam int THR_HIGH_RST = FRAMES * HIGH_PCT_RST / PCT_DIV;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_PERCENT  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_PERCENT = 1'd1;

   // request kinds as they appear on the port
   localparam logic [KIND_BITS-1:0] KIND_TAKE    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ADDREF  = 2'd2;

   typedef enum logic [1:0] {
      OP_TAKE    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_ADDREF  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_REL_FREE  = 2'd1,
      ST_ADD_FREE  = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   // one classified command waiting in the queue
   typedef struct packed {
      op_type                op;
      logic                  idx_ok;
      logic [FRAME_BITS-1:0] idx;
   } cmd_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic [THR_BITS-1:0] low;
      logic [THR_BITS-1:0] high;
   } thr_type;

endpackage

`default_nettype wire

// File: design/rbpw_csr.sv
`default_nettype none

module rbpw_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_write_enable,
   input  wire [rbpw_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire [rbpw_pkg::PCT_BITS-1:0]      csr_write_data,
   output rbpw_pkg::thr_type                 thr
);
   import rbpw_pkg::*;

   logic [PCT_BITS-1:0]  low_pct_ff, low_pct_in;
   logic [PCT_BITS-1:0]  upper_pct_ff, upper_pct_in;
   logic [THR_BITS-1:0]  thr_low_ff, thr_low_in;
   logic [THR_BITS-1:0]  thr_high_ff, thr_high_in;
   logic [SCALED_BITS-1:0] low_scaled, high_scaled;
   logic [PROD_BITS-1:0]   low_prod, high_prod;

   // register writes
   always_comb begin
      low_pct_in   = low_pct_ff;
      upper_pct_in = upper_pct_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOW_PERCENT:  low_pct_in   = csr_write_data;
            CSR_HIGH_PERCENT: upper_pct_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // percent to frame count, divide by 100 through a reciprocal
   always_comb begin
      low_scaled  = SCALED_BITS'(low_pct_ff) * SCALED_BITS'(FRAMES);
      high_scaled = SCALED_BITS'(upper_pct_ff) * SCALED_BITS'(FRAMES);
      low_prod    = PROD_BITS'(low_scaled) * PROD_BITS'(RECIP);
      high_prod   = PROD_BITS'(high_scaled) * PROD_BITS'(RECIP);
      thr_low_in  = THR_BITS'(low_prod >> RECIP_SHIFT);
      thr_high_in = THR_BITS'(high_prod >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_pct_ff   <= PCT_BITS'(LOW_PCT_RST);
         upper_pct_ff <= PCT_BITS'(HIGH_PCT_RST);
         thr_low_ff   <= THR_BITS'(THR_LOW_RST);
         thr_high_ff  <= THR_BITS'(THR_HIGH_RST);
      end else begin
         low_pct_ff   <= low_pct_in;
         upper_pct_ff <= upper_pct_in;
         thr_low_ff   <= thr_low_in;
         thr_high_ff  <= thr_high_in;
      end
   end

   assign thr.low  = thr_low_ff;
   assign thr.high = thr_high_ff;

endmodule

`default_nettype wire

// File: design/rbpw_front.sv
`default_nettype none

module rbpw_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [rbpw_pkg::KIND_BITS-1:0]    req_kind,
   input  wire [rbpw_pkg::INDEX_BITS-1:0]   req_frame_index,
   output rbpw_pkg::cmd_head_type           head,
   input  wire                              pop
);
   import rbpw_pkg::*;

   cmd_type                     q_ff [CMD_Q_DEPTH];
   logic [CMD_Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_Q_FILL_BITS-1:0]  fill_ff, fill_in;
   logic                        push;
   cmd_type                     cmd_new;

   // classify the incoming request
   always_comb begin
      unique case (req_kind)
         KIND_TAKE:    cmd_new.op = OP_TAKE;
         KIND_RELEASE: cmd_new.op = OP_RELEASE;
         KIND_ADDREF:  cmd_new.op = OP_ADDREF;
         default:      cmd_new.op = OP_NONE;
      endcase
      cmd_new.idx_ok = (32'(req_frame_index) < 32'(FRAMES));
      cmd_new.idx    = FRAME_BITS'(req_frame_index);
   end

   assign busy = (fill_ff == CMD_Q_FILL_BITS'(CMD_Q_DEPTH));
   assign push = start && !busy;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMD_Q_PTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff + CMD_Q_FILL_BITS'(push) - CMD_Q_FILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: design/rbpw_back.sv
`default_nettype none

module rbpw_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire rbpw_pkg::cmd_head_type      head,
   output logic                             pop,
   input  wire rbpw_pkg::thr_type           thr,
   output logic                             rsp_valid,
   output logic [rbpw_pkg::INDEX_BITS-1:0]  rsp_granted_index,
   output logic                             rsp_granted,
   output logic                             rsp_returned,
   output logic [rbpw_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_low_notice,
   output logic                             rsp_normal_notice,
   output logic [rbpw_pkg::FREE_BITS-1:0]   rsp_free_count
);
   import rbpw_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int CMP_BITS = (USE_BITS > THR_BITS) ? USE_BITS : THR_BITS;

   typedef enum logic [1:0] {
      S_FETCH = 2'b01,
      S_EXEC  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // link and count memories, plus valid bits standing for the reset image
   logic [FRAME_BITS-1:0] link_mem  [FRAMES];
   logic [COUNT_BITS-1:0] count_mem [FRAMES];
   logic [FRAMES-1:0]     link_vld_ff, link_vld_in;
   logic [FRAMES-1:0]     count_vld_ff, count_vld_in;
   logic [FRAME_BITS-1:0] link_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;

   // pool state
   logic [FRAME_BITS-1:0] head_ff, head_in;
   logic [USE_BITS-1:0]   use_ff, use_in;
   logic                  low_ff, low_in;

   // command being executed
   op_type                op_ff;
   logic                  idx_ok_ff;
   logic [FRAME_BITS-1:0] addr_ff;
   logic [FRAME_BITS-1:0] rd_addr;

   // write strobes
   logic                  count_we, link_we;
   logic [COUNT_BITS-1:0] count_wdata;

   // values seen in the execute cycle
   logic [COUNT_BITS-1:0] count_cur;
   logic [FRAME_BITS-1:0] link_cur;
   logic [USE_BITS-1:0]   free_after;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] gidx_ff, gidx_in;
   logic                  granted_ff, granted_in;
   logic                  returned_ff, returned_in;
   status_type            status_ff, status_in;
   logic                  low_n_ff, low_n_in;
   logic                  norm_n_ff, norm_n_in;
   logic [FREE_BITS-1:0]  free_ff, free_in;

   // sequencer: fetch reads the entry, execute updates it
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         S_FETCH: begin
            if (head.valid) begin
               pop      = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_FETCH;
         default: state_in = S_FETCH;
      endcase
   end

   assign rd_addr = (head.cmd.op == OP_TAKE) ? head_ff : head.cmd.idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FETCH;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the command and read both memories at one address
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff       <= head.cmd.op;
         idx_ok_ff   <= head.cmd.idx_ok;
         addr_ff     <= rd_addr;
         link_rd_ff  <= link_mem[rd_addr];
         count_rd_ff <= count_mem[rd_addr];
      end
   end

   // entries never written read as their reset values
   always_comb begin
      count_cur = count_vld_ff[addr_ff] ? count_rd_ff : '0;
      if (link_vld_ff[addr_ff]) begin
         link_cur = link_rd_ff;
      end else if (addr_ff == '0) begin
         link_cur = '0;
      end else begin
         link_cur = addr_ff - FRAME_BITS'(1);
      end
   end

   // execute one command
   always_comb begin
      head_in     = head_ff;
      use_in      = use_ff;
      low_in      = low_ff;
      count_we    = 1'b0;
      count_wdata = count_cur;
      link_we     = 1'b0;
      gidx_in     = '0;
      granted_in  = 1'b0;
      returned_in = 1'b0;
      status_in   = ST_OK;
      low_n_in    = 1'b0;
      norm_n_in   = 1'b0;
      free_after  = USE_BITS'(FRAMES) - use_ff;

      if (state_ff == S_EXEC) begin
         unique case (op_ff)
            OP_TAKE: begin
               if (use_ff < USE_BITS'(FRAMES)) begin
                  head_in     = link_cur;
                  use_in      = use_ff + USE_BITS'(1);
                  count_we    = 1'b1;
                  count_wdata = COUNT_BITS'(1);
                  gidx_in     = INDEX_BITS'(addr_ff);
                  granted_in  = 1'b1;
                  free_after  = USE_BITS'(FRAMES) - use_in;
                  if (!low_ff &&
                      CMP_BITS'(free_after) <= CMP_BITS'(thr.low)) begin
                     low_in   = 1'b1;
                     low_n_in = 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               if (!idx_ok_ff || count_cur == '0) begin
                  status_in = ST_REL_FREE;
               end else begin
                  count_we    = 1'b1;
                  count_wdata = count_cur - COUNT_BITS'(1);
                  if (count_cur == COUNT_BITS'(1)) begin
                     link_we     = 1'b1;
                     head_in     = addr_ff;
                     if (use_ff != '0) begin
                        use_in = use_ff - USE_BITS'(1);
                     end
                     returned_in = 1'b1;
                     free_after  = USE_BITS'(FRAMES) - use_in;
                     if (low_ff &&
                         CMP_BITS'(free_after) >= CMP_BITS'(thr.high)) begin
                        low_in    = 1'b0;
                        norm_n_in = 1'b1;
                     end
                  end
               end
            end
            OP_ADDREF: begin
               if (!idx_ok_ff || count_cur == '0) begin
                  status_in = ST_ADD_FREE;
               end else if (count_cur == COUNT_MAX) begin
                  status_in = ST_SATURATED;
               end else begin
                  count_we    = 1'b1;
                  count_wdata = count_cur + COUNT_BITS'(1);
               end
            end
            default: ;
         endcase
      end

      rsp_valid_in = (state_ff == S_EXEC);
      free_in      = FREE_BITS'(free_after);
   end

   // valid bits follow the memory writes
   always_comb begin
      count_vld_in = count_vld_ff;
      link_vld_in  = link_vld_ff;
      if (count_we) begin
         count_vld_in[addr_ff] = 1'b1;
      end
      if (link_we) begin
         link_vld_in[addr_ff] = 1'b1;
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[addr_ff] <= count_wdata;
      end
      if (link_we) begin
         link_mem[addr_ff] <= head_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= FRAME_BITS'(FRAMES - 1);
         use_ff       <= '0;
         low_ff       <= 1'b0;
         count_vld_ff <= '0;
         link_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         use_ff       <= use_in;
         low_ff       <= low_in;
         count_vld_ff <= count_vld_in;
         link_vld_ff  <= link_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      gidx_ff     <= gidx_in;
      granted_ff  <= granted_in;
      returned_ff <= returned_in;
      status_ff   <= status_in;
      low_n_ff    <= low_n_in;
      norm_n_ff   <= norm_n_in;
      free_ff     <= free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = gidx_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_returned      = returned_ff;
   assign rsp_status        = status_ff;
   assign rsp_low_notice    = low_n_ff;
   assign rsp_normal_notice = norm_n_ff;
   assign rsp_free_count    = free_ff;

`ifndef SYNTHESIS
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results closer than two cycles");

   a_exec_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == S_EXEC) && rsp_valid_in)
      else $error("popped command not executed");

   a_use_bound: assert property (@(posedge clock) disable iff (reset)
      use_ff <= USE_BITS'(FRAMES))
      else $error("in-use count above pool size");

   a_grant_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> (rsp_status == ST_OK) && !rsp_returned
      && !rsp_normal_notice)
      else $error("grant mixed with release flags");

   a_notice_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_low_notice |-> low_ff && !rsp_normal_notice)
      else $error("low notice without low state");
`endif

endmodule

`default_nettype wire

// File: design/refcounted_block_pool_watermark.sv
`default_nettype none

// Reference-counted pool of 64 fixed buffers with a LIFO free list and
// low/high watermark notices.
// Command channel: a command (req_kind, req_frame_index) transfers at a
// rising edge where start is high and busy is low. Kinds: take, release,
// add reference; the fourth code does nothing but still gets a result.
// Result channel: every command gives exactly one result, shown for one
// cycle with rsp_valid high; the receiver cannot stall it.
// Path: with no queue backlog a command passes from the queue entry
// through the fetch latch and the result registers to the ports.
// Issue: the executor takes a new command only after it has executed
// the last one, alternating fetch and execute for the read-modify-write of
// the link and count memories. A two-entry command queue sits ahead of
// the executor, so busy rises only when two commands are waiting.
// Configuration: csr_write_enable with csr_index 0 (low percent) or 1
// (high percent) stores 7-bit data at that edge; the thresholds are
// registered from it in the cycle after. Write only while the pool is idle.
// Reset: synchronous, active high; the free list is full, all counts are
// zero, the state is normal, percents are 25 and 75. No clearing pass.

module refcounted_block_pool_watermark (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [rbpw_pkg::KIND_BITS-1:0]    req_kind,
   input  wire [rbpw_pkg::INDEX_BITS-1:0]   req_frame_index,
   output logic                             rsp_valid,
   output logic [rbpw_pkg::INDEX_BITS-1:0]  rsp_granted_index,
   output logic                             rsp_granted,
   output logic                             rsp_returned,
   output logic [rbpw_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_low_notice,
   output logic                             rsp_normal_notice,
   output logic [rbpw_pkg::FREE_BITS-1:0]   rsp_free_count,
   input  wire                              csr_write_enable,
   input  wire [rbpw_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire [rbpw_pkg::PCT_BITS-1:0]     csr_write_data
);
   import rbpw_pkg::*;

   cmd_head_type cmd_head;
   logic         cmd_pop;
   thr_type      thr;

   // watermark registers and thresholds
   rbpw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .thr              (thr)
   );

   // command intake and queue
   rbpw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_frame_index (req_frame_index),
      .head            (cmd_head),
      .pop             (cmd_pop)
   );

   // pool executor
   rbpw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (cmd_head),
      .pop               (cmd_pop),
      .thr               (thr),
      .rsp_valid         (rsp_valid),
      .rsp_granted_index (rsp_granted_index),
      .rsp_granted       (rsp_granted),
      .rsp_returned      (rsp_returned),
      .rsp_status        (rsp_status),
      .rsp_low_notice    (rsp_low_notice),
      .rsp_normal_notice (rsp_normal_notice),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

`default_nettype wire

// File: bench/tb_refcounted_block_pool_watermark.sv
`timescale 1ns / 1ps

module tb_refcounted_block_pool_watermark;
   import rbpw_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 64;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // one command as it goes onto the request ports
   typedef struct {
      op_type                kind;
      logic [INDEX_BITS-1:0] frame_index;
   } pool_cmd_type;

   // one result as the pool should report it
   typedef struct {
      logic [INDEX_BITS-1:0] granted_index;
      logic                  granted;
      logic                  returned;
      status_type            status;
      logic                  low_notice;
      logic                  normal_notice;
      logic [FREE_BITS-1:0]  free_count;
   } pool_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [KIND_BITS-1:0]    req_kind = '0;
   logic [INDEX_BITS-1:0]   req_frame_index = '0;
   logic                    rsp_valid;
   logic [INDEX_BITS-1:0]   rsp_granted_index;
   logic                    rsp_granted;
   logic                    rsp_returned;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic                    rsp_low_notice;
   logic                    rsp_normal_notice;
   logic [FREE_BITS-1:0]    rsp_free_count;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_LOW_PERCENT;
   logic [PCT_BITS-1:0]     csr_write_data = '0;

   // shadow of the pool
   logic [FRAME_BITS-1:0]   list_top;
   logic [FRAME_BITS-1:0]   link_of [FRAMES];
   logic [COUNT_BITS-1:0]   ref_cnt [FRAMES];
   int                      frames_in_use;
   logic                    in_low_water;
   logic [PCT_BITS-1:0]     low_pct;
   logic [PCT_BITS-1:0]     upper_pct;

   pool_cmd_type            pending [$];
   pool_result_type         expected_results [$];
   pool_cmd_type            drive_cmd;
   pool_result_type         want_rsp;
   logic                    fired = 1'b0;
   int                      idle_pct = 0;
   bit                      fill_mode = 1'b1;
   int                      mismatch_count = 0;
   int                      quiet_cycles = 0;

   refcounted_block_pool_watermark u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_frame_index   (req_frame_index),
      .rsp_valid         (rsp_valid),
      .rsp_granted_index (rsp_granted_index),
      .rsp_granted       (rsp_granted),
      .rsp_returned      (rsp_returned),
      .rsp_status        (rsp_status),
      .rsp_low_notice    (rsp_low_notice),
      .rsp_normal_notice (rsp_normal_notice),
      .rsp_free_count    (rsp_free_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pct_threshold(input logic [PCT_BITS-1:0] pct);
      return (FRAMES * int'(pct)) / PCT_DIV;
   endfunction

   task automatic pool_reset();
      list_top = FRAME_BITS'(FRAMES - 1);
      for (int i = 0; i < FRAMES; i++) begin
         link_of[i] = (i == 0) ? '0 : FRAME_BITS'(i - 1);
         ref_cnt[i] = '0;
      end
      frames_in_use = 0;
      in_low_water = 1'b0;
      low_pct = PCT_BITS'(LOW_PCT_RST);
      upper_pct = PCT_BITS'(HIGH_PCT_RST);
   endtask

   // apply one command to the shadow pool and queue the result it should give
   function automatic void pool_apply(input op_type op, input logic [INDEX_BITS-1:0] idx);
      pool_result_type r;
      logic [FRAME_BITS-1:0] top;
      int free_now;
      r.granted_index = '0;
      r.granted = 1'b0;
      r.returned = 1'b0;
      r.status = ST_OK;
      r.low_notice = 1'b0;
      r.normal_notice = 1'b0;
      case (op)
         OP_TAKE: begin
            if (frames_in_use < FRAMES) begin
               top = list_top;
               list_top = link_of[top];
               ref_cnt[top] = COUNT_BITS'(1);
               frames_in_use++;
               r.granted_index = top;
               r.granted = 1'b1;
               free_now = FRAMES - frames_in_use;
               if (!in_low_water && free_now <= pct_threshold(low_pct)) begin
                  in_low_water = 1'b1;
                  r.low_notice = 1'b1;
               end
            end
         end
         OP_RELEASE: begin
            if (ref_cnt[idx] == '0) begin
               r.status = ST_REL_FREE;
            end else begin
               ref_cnt[idx] = ref_cnt[idx] - COUNT_BITS'(1);
               if (ref_cnt[idx] == '0) begin
                  link_of[idx] = list_top;
                  list_top = idx;
                  if (frames_in_use > 0) frames_in_use--;
                  r.returned = 1'b1;
                  free_now = FRAMES - frames_in_use;
                  if (in_low_water && free_now >= pct_threshold(upper_pct)) begin
                     in_low_water = 1'b0;
                     r.normal_notice = 1'b1;
                  end
               end
            end
         end
         OP_ADDREF: begin
            if (ref_cnt[idx] == '0) r.status = ST_ADD_FREE;
            else if (ref_cnt[idx] == COUNT_MAX) r.status = ST_SATURATED;
            else ref_cnt[idx] = ref_cnt[idx] + COUNT_BITS'(1);
         end
         default: ;
      endcase
      r.free_count = FREE_BITS'(FRAMES - frames_in_use);
      expected_results.push_back(r);
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic pool_cmd_type make_cmd(input op_type op, input int idx);
      pool_cmd_type c;
      c.kind = op;
      c.frame_index = INDEX_BITS'(idx);
      return c;
   endfunction

   // a buffer that currently holds references, or any index if none does
   function automatic logic [INDEX_BITS-1:0] pick_held_frame();
      logic [INDEX_BITS-1:0] held [$];
      for (int i = 0; i < FRAMES; i++)
         if (ref_cnt[i] != '0) held.push_back(INDEX_BITS'(i));
      if (held.size() == 0) return INDEX_BITS'($urandom_range(FRAMES - 1));
      return held[$urandom_range(held.size() - 1)];
   endfunction

   // pool swings between filling up and draining so both watermarks get crossed
   function automatic pool_cmd_type next_random_cmd();
      pool_cmd_type c;
      int roll;
      if (fill_mode && frames_in_use == FRAMES && $urandom_range(3) == 0)
         fill_mode = 1'b0;
      else if (!fill_mode && (frames_in_use == 0 ||
               (frames_in_use < 8 && $urandom_range(15) == 0)))
         fill_mode = 1'b1;
      roll = $urandom_range(99);
      c.frame_index = INDEX_BITS'($urandom_range(FRAMES - 1));
      if (roll < 10) begin
         // noise: any kind, any index
         c.kind = op_type'($urandom_range(3));
      end else if (fill_mode) begin
         if (roll < 65) begin
            c.kind = OP_TAKE;
         end else begin
            c.kind = (roll < 80) ? OP_ADDREF : OP_RELEASE;
            c.frame_index = pick_held_frame();
         end
      end else begin
         if (roll < 20) begin
            c.kind = OP_TAKE;
         end else begin
            c.kind = (roll < 35) ? OP_ADDREF : OP_RELEASE;
            c.frame_index = pick_held_frame();
         end
      end
      return c;
   endfunction

   // driver: hold a command until it transfers, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || fired) begin
         if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            drive_cmd = pending.pop_front();
            req_kind <= drive_cmd.kind;
            req_frame_index <= drive_cmd.frame_index;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each command transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         fired = 1'b0;
         quiet_cycles = 0;
      end else begin
         fired = start && !busy;
         if (csr_write_enable) begin
            if (csr_index == CSR_LOW_PERCENT) low_pct = csr_write_data;
            else upper_pct = csr_write_data;
         end
         if (fired) pool_apply(op_type'(req_kind), req_frame_index);
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, free_count %0d",
                        $time, rsp_free_count);
               mismatch_count++;
            end else begin
               want_rsp = expected_results.pop_front();
               check_field("granted_index", 8'(want_rsp.granted_index), 8'(rsp_granted_index));
               check_field("granted", 8'(want_rsp.granted), 8'(rsp_granted));
               check_field("returned", 8'(want_rsp.returned), 8'(rsp_returned));
               check_field("status", 8'(want_rsp.status), 8'(rsp_status));
               check_field("low_notice", 8'(want_rsp.low_notice), 8'(rsp_low_notice));
               check_field("normal_notice", 8'(want_rsp.normal_notice),
                           8'(rsp_normal_notice));
               check_field("free_count", 8'(want_rsp.free_count), 8'(rsp_free_count));
            end
         end
         // watchdog on cycles without any transfer
         if (fired || rsp_valid || csr_write_enable) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // wait until every queued command transferred and every result came back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || (start && !fired) || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] which,
                            input logic [PCT_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // keep a short backlog so choices follow the current pool state
   task automatic run_random(input int n);
      int made;
      made = 0;
      while (made < n) begin
         @(posedge clock);
         #1;
         while (pending.size() < 4 && made < n) begin
            pending.push_back(next_random_cmd());
            made++;
         end
      end
   endtask

   task automatic run_phase(input bit set_regs, input logic [PCT_BITS-1:0] lo,
                            input logic [PCT_BITS-1:0] hi, input int idle);
      if (set_regs) begin
         write_csr(CSR_LOW_PERCENT, lo);
         write_csr(CSR_HIGH_PERCENT, hi);
         repeat (2) @(posedge clock);
      end
      idle_pct = idle;
      run_random(PHASE_ITEMS);
      wait_drained();
   endtask

   initial begin
      logic [INDEX_BITS-1:0] sat_frame;
      pool_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every kind, index extremes, error cases, LIFO reuse
      idle_pct = 0;
      pending.push_back(make_cmd(OP_TAKE, 0));
      pending.push_back(make_cmd(OP_TAKE, 63));
      pending.push_back(make_cmd(OP_ADDREF, 63));
      pending.push_back(make_cmd(OP_ADDREF, 62));
      pending.push_back(make_cmd(OP_RELEASE, 63));
      pending.push_back(make_cmd(OP_RELEASE, 63));
      pending.push_back(make_cmd(OP_RELEASE, 63));
      pending.push_back(make_cmd(OP_ADDREF, 63));
      pending.push_back(make_cmd(OP_RELEASE, 0));
      pending.push_back(make_cmd(OP_ADDREF, 0));
      pending.push_back(make_cmd(OP_NONE, 63));
      pending.push_back(make_cmd(OP_NONE, 0));
      pending.push_back(make_cmd(OP_NONE, 42));
      pending.push_back(make_cmd(OP_RELEASE, 62));
      pending.push_back(make_cmd(OP_RELEASE, 62));
      pending.push_back(make_cmd(OP_TAKE, 21));
      pending.push_back(make_cmd(OP_ADDREF, 62));
      pending.push_back(make_cmd(OP_TAKE, 42));
      pending.push_back(make_cmd(OP_RELEASE, 21));
      wait_drained();

      // count saturation on one held buffer, then release it down past zero
      idle_pct = 11;
      sat_frame = pick_held_frame();
      for (int i = 0; i < 256; i++) pending.push_back(make_cmd(OP_ADDREF, sat_frame));
      for (int i = 0; i < 256; i++) pending.push_back(make_cmd(OP_RELEASE, sat_frame));
      wait_drained();

      run_phase(1'b0, '0, '0, 0);
      run_phase(1'b1, 7'd0, 7'd100, 65);
      run_phase(1'b1, 7'd100, 7'd0, 0);
      run_phase(1'b1, 7'd127, 7'd127, 11);
      run_phase(1'b1, PCT_BITS'($urandom_range(127)), PCT_BITS'($urandom_range(127)), 65);
      run_phase(1'b1, PCT_BITS'(LOW_PCT_RST), PCT_BITS'(HIGH_PCT_RST), 0);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
